// ----- rtl/dpd_pkg.sv -----
// Shared types and constants for the DNA pair p-distance block.
`timescale 1ns / 1ps
package dpd_pkg;

   localparam int CNT_W    = 17;
   localparam int DIST_W   = 24;
   localparam int FRAC_W   = 16;
   localparam int CNT_SAT  = 131071;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;
   localparam logic [DIST_W-1:0] ONE_Q16  = 24'h010000;

   // per-pair totals handed from the front end to the divider
   typedef struct packed {
      logic [CNT_W-1:0] mismatch;
      logic [CNT_W-1:0] ambiguous;
      logic [CNT_W-1:0] positions;
   } pair_counts_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- rtl/dpd_front.sv -----
// Front end: classifies each aligned position and accumulates per-pair counts.
`timescale 1ns / 1ps
module dpd_front
   import dpd_pkg::*;
#(
   parameter int MAX_LEN = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_base_a,
   input  logic [7:0]            req_base_b,
   input  logic                  req_last,
   input  queue_status_type      queue_status,
   output logic                  push,
   output pair_counts_type       push_data
);

   localparam int CAP_INT = (MAX_LEN < CNT_SAT) ? MAX_LEN : CNT_SAT;
   localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_INT);

   localparam logic [7:0] CH_GAP  = 8'h2D;  // '-'
   localparam logic [7:0] CH_PLUS = 8'h2B;  // '+'
   localparam logic [7:0] CH_N    = 8'h4E;  // 'N'
   localparam logic [7:0] CH_LA   = 8'h61;  // 'a'
   localparam logic [7:0] CH_LZ   = 8'h7A;  // 'z'
   localparam logic [7:0] CASE_OFS = 8'h20;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFS : c;
   endfunction

   // bit0 A, bit1 C, bit2 G, bit3 T; unknown codes give the empty set
   function automatic logic [3:0] base_set(input logic [7:0] c);
      logic [3:0] m;
      unique case (c)
         8'h41:   m = 4'd1;   // A
         8'h43:   m = 4'd2;   // C
         8'h47:   m = 4'd4;   // G
         8'h54:   m = 4'd8;   // T
         8'h4D:   m = 4'd3;   // M
         8'h52:   m = 4'd5;   // R
         8'h57:   m = 4'd9;   // W
         8'h53:   m = 4'd6;   // S
         8'h59:   m = 4'd10;  // Y
         8'h4B:   m = 4'd12;  // K
         8'h56:   m = 4'd7;   // V
         8'h48:   m = 4'd11;  // H
         8'h44:   m = 4'd13;  // D
         8'h42:   m = 4'd14;  // B
         default: m = 4'd0;
      endcase
      return m;
   endfunction

   function automatic logic is_single(input logic [3:0] m);
      return $countones(m) == 1;
   endfunction

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v < CAP) ? v + CNT_W'(1) : v;
   endfunction

   logic [CNT_W-1:0] mismatch_ff, mismatch_in;
   logic [CNT_W-1:0] ambiguous_ff, ambiguous_in;
   logic [CNT_W-1:0] positions_ff, positions_in;

   logic [7:0] a, b;
   logic [3:0] ma, mb;
   logic       gap_a, gap_b, is_mis, is_amb, accept;
   logic [CNT_W-1:0] mis_next, amb_next, pos_next;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      a     = upcase(req_base_a);
      b     = upcase(req_base_b);
      ma    = base_set(a);
      mb    = base_set(b);
      gap_a = (a == CH_GAP) || (a == CH_PLUS);
      gap_b = (b == CH_GAP) || (b == CH_PLUS);
      priority if (gap_a || gap_b) begin
         is_mis = (a == CH_GAP && b == CH_PLUS) || (a == CH_PLUS && b == CH_GAP);
      end else if (a == CH_N || b == CH_N) begin
         is_mis = 1'b0;
      end else if (is_single(ma) || is_single(mb)) begin
         is_mis = (ma & mb) == 4'd0;
      end else begin
         is_mis = (ma != 4'd0) && (mb != 4'd0) && ((ma & mb) == 4'd0);
      end
      is_amb = gap_a || gap_b || (a == CH_N) || (b == CH_N);
   end

   always_comb begin
      mis_next = is_mis ? sat_inc(mismatch_ff) : mismatch_ff;
      amb_next = is_amb ? sat_inc(ambiguous_ff) : ambiguous_ff;
      pos_next = sat_inc(positions_ff);

      push                = accept && req_last;
      push_data.mismatch  = mis_next;
      push_data.ambiguous = amb_next;
      push_data.positions = pos_next;

      mismatch_in  = mismatch_ff;
      ambiguous_in = ambiguous_ff;
      positions_in = positions_ff;
      if (accept) begin
         if (req_last) begin
            mismatch_in  = '0;
            ambiguous_in = '0;
            positions_in = '0;
         end else begin
            mismatch_in  = mis_next;
            ambiguous_in = amb_next;
            positions_in = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mismatch_ff  <= '0;
         ambiguous_ff <= '0;
         positions_ff <= '0;
      end else begin
         mismatch_ff  <= mismatch_in;
         ambiguous_ff <= ambiguous_in;
         positions_ff <= positions_in;
      end
   end

endmodule

// ----- rtl/dpd_queue.sv -----
// Short queue of per-pair totals between the front end and the divider.
`timescale 1ns / 1ps
module dpd_queue
   import dpd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pair_counts_type   push_data,
   input  logic              pop,
   output pair_counts_type   head,
   output queue_status_type  status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

   pair_counts_type mem [QUEUE_DEPTH];

   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0] fill_ff, fill_in;
   logic               do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign status.full  = (fill_ff == CNT_W_Q'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W_Q'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/dpd_back.sv -----
// Back end: restoring divider for the Q8.16 distance plus the result register.
`timescale 1ns / 1ps
module dpd_back
   import dpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  pair_counts_type      head,
   input  queue_status_type     queue_status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DIST_W-1:0]    rsp_distance,
   output logic [CNT_W-1:0]     rsp_mismatch_count,
   output logic [CNT_W-1:0]     rsp_usable_count
);

   localparam int DVD_W  = CNT_W + FRAC_W;
   localparam int STEP_W = $clog2(DVD_W + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;     // dividend shifting out, quotient shifting in
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;     // usable count, also the divisor
   logic [CNT_W-1:0]  mis_ff, mis_in;

   logic              out_valid_ff, out_valid_in;
   logic [DIST_W-1:0] out_dist_ff, out_dist_in;
   logic [CNT_W-1:0]  out_mis_ff, out_mis_in;
   logic [CNT_W-1:0]  out_use_ff, out_use_in;

   logic [CNT_W:0]    rem_sh, rem_diff;
   logic              ge, slot_free;
   logic [CNT_W-1:0]  usable;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && !queue_status.empty;

   always_comb begin
      usable = (head.positions >= head.ambiguous) ? head.positions - head.ambiguous : '0;
      rem_sh   = {rem_ff, dvd_ff[DVD_W-1]};
      rem_diff = rem_sh - {1'b0, div_ff};
      ge       = (rem_sh >= {1'b0, div_ff});

      state_in     = state_ff;
      step_in      = step_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      mis_in       = mis_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_dist_in  = out_dist_ff;
      out_mis_in   = out_mis_ff;
      out_use_in   = out_use_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_status.empty) begin
               mis_in  = head.mismatch;
               div_in  = usable;
               rem_in  = '0;
               step_in = STEP_W'(DVD_W);
               if (usable == '0) begin
                  // every position ambiguous: distance is 1.0
                  dvd_in   = DVD_W'(ONE_Q16);
                  state_in = ST_WRITE;
               end else begin
                  dvd_in   = {head.mismatch, FRAC_W'(0)};
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            rem_in  = ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            dvd_in  = {dvd_ff[DVD_W-2:0], ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_dist_in  = (dvd_ff[DVD_W-1:DIST_W] != '0) ? DIST_MAX
                                                             : dvd_ff[DIST_W-1:0];
               out_mis_in   = mis_ff;
               out_use_in   = div_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      mis_ff      <= mis_in;
      out_dist_ff <= out_dist_in;
      out_mis_ff  <= out_mis_in;
      out_use_ff  <= out_use_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_distance       = out_dist_ff;
   assign rsp_mismatch_count = out_mis_ff;
   assign rsp_usable_count   = out_use_ff;

endmodule

// ----- rtl/dna_pair_p_distance.sv -----
// Top level: streaming p-distance of two aligned DNA sequences.
// Throughput: one position per cycle; req_ready drops only while the pair queue
//   (two entries) is full.
// A result shows on rsp_valid once the last position's totals have passed the queue,
//   33 divider iterations and the write; the iterations are skipped when usable is 0.
// Reset (synchronous, active high) clears the counters, queue and result register.
`timescale 1ns / 1ps
module dna_pair_p_distance
   import dpd_pkg::*;
#(
   parameter int MAX_LEN = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_base_a,
   input  logic [7:0]          req_base_b,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DIST_W-1:0]   rsp_distance,
   output logic [CNT_W-1:0]    rsp_mismatch_count,
   output logic [CNT_W-1:0]    rsp_usable_count
);

   queue_status_type queue_status;
   pair_counts_type  push_data, head;
   logic             push, pop;

   dpd_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_base_a   (req_base_a),
      .req_base_b   (req_base_b),
      .req_last     (req_last),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   dpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (queue_status)
   );

   dpd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .queue_status       (queue_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_distance       (rsp_distance),
      .rsp_mismatch_count (rsp_mismatch_count),
      .rsp_usable_count   (rsp_usable_count)
   );

endmodule

// ----- rtl/dpd_checker.sv -----
// Port-level checker for the p-distance block, bound to the top level.
`timescale 1ns / 1ps
module dpd_checker
   import dpd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [7:0]          req_base_a,
   input logic [7:0]          req_base_b,
   input logic                req_last,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [DIST_W-1:0]   rsp_distance,
   input logic [CNT_W-1:0]    rsp_mismatch_count,
   input logic [CNT_W-1:0]    rsp_usable_count
);

   // a stalled result transaction keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance)
         && $stable(rsp_mismatch_count) && $stable(rsp_usable_count))
      else $error("result changed while stalled");

   // no usable positions reads as 1.0
   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_usable_count == '0 |-> rsp_distance == ONE_Q16)
      else $error("zero denominator must give 1.0");

   // no mismatches over usable positions gives zero distance
   a_zero_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_usable_count != '0 && rsp_mismatch_count == '0
         |-> rsp_distance == '0)
      else $error("zero mismatches must give zero distance");

   // a result equal to its count ratio of one when counts match
   a_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_usable_count != '0 && rsp_mismatch_count == rsp_usable_count
         |-> rsp_distance == ONE_Q16)
      else $error("equal counts must give 1.0");

   // the result register comes out of reset empty
   a_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind dna_pair_p_distance dpd_checker u_dpd_checker (.*);

// ----- bench/dpd_result_check.sv -----
// Monitors both channels of the p-distance block, predicts each pair result and compares it.
`timescale 1ns / 1ps
module dpd_result_check
   import dpd_pkg::*;
#(
   parameter int MAX_LEN = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [7:0]        req_base_a,
   input  logic [7:0]        req_base_b,
   input  logic              req_last,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [DIST_W-1:0] rsp_distance,
   input  logic [CNT_W-1:0]  rsp_mismatch_count,
   input  logic [CNT_W-1:0]  rsp_usable_count,
   output int                fail_count,
   output int                pending
);

   localparam logic [7:0] CH_GAP  = "-";
   localparam logic [7:0] CH_PLUS = "+";
   localparam logic [7:0] CH_N    = "N";
   localparam int unsigned TALLY_CAP = (MAX_LEN < CNT_SAT) ? MAX_LEN : CNT_SAT;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [CNT_W-1:0]  mismatch_count;
      logic [CNT_W-1:0]  usable_count;
   } pair_result_type;

   pair_result_type pair_results_due[$];
   int unsigned  mismatch_tally;
   int unsigned  ambiguous_tally;
   int unsigned  position_tally;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   // one bit per base: A, C, G, T; unknown codes give the empty set
   function automatic logic [3:0] iupac_set(input logic [7:0] c);
      case (c)
         "A": return 4'b0001;
         "C": return 4'b0010;
         "G": return 4'b0100;
         "T": return 4'b1000;
         "M": return 4'b0011;
         "R": return 4'b0101;
         "W": return 4'b1001;
         "S": return 4'b0110;
         "Y": return 4'b1010;
         "K": return 4'b1100;
         "V": return 4'b0111;
         "H": return 4'b1011;
         "D": return 4'b1101;
         "B": return 4'b1110;
         default: return 4'b0000;
      endcase
   endfunction

   function automatic logic bases_clash(input logic [7:0] a, input logic [7:0] b);
      logic [3:0] set_a;
      logic [3:0] set_b;
      set_a = iupac_set(a);
      set_b = iupac_set(b);
      if (a == CH_GAP || a == CH_PLUS || b == CH_GAP || b == CH_PLUS)
         return (a == CH_GAP && b == CH_PLUS) || (a == CH_PLUS && b == CH_GAP);
      if (a == CH_N || b == CH_N)
         return 1'b0;
      if ($countones(set_a) == 1 || $countones(set_b) == 1)
         return (set_a & set_b) == 4'b0000;
      // two ambiguity codes clash only when both are known and disjoint
      return set_a != 4'b0000 && set_b != 4'b0000 && (set_a & set_b) == 4'b0000;
   endfunction

   function automatic int unsigned bump(input int unsigned v);
      return (v < TALLY_CAP) ? v + 1 : v;
   endfunction

   function automatic pair_result_type p_distance_q16(input int unsigned mismatches,
                                                      input int unsigned ambiguous,
                                                      input int unsigned positions);
      pair_result_type r;
      int unsigned usable;
      longint unsigned quotient;
      usable = (positions >= ambiguous) ? positions - ambiguous : 0;
      if (usable == 0) begin
         quotient = ONE_Q16;
      end else begin
         quotient = (longint'(mismatches) << FRAC_W) / longint'(usable);
         if (quotient > DIST_MAX)
            quotient = DIST_MAX;
      end
      r.distance       = quotient[DIST_W-1:0];
      r.mismatch_count = mismatches[CNT_W-1:0];
      r.usable_count   = usable[CNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      logic [7:0]      a;
      logic [7:0]      b;
      pair_result_type due;
      if (reset) begin
         mismatch_tally  = 0;
         ambiguous_tally = 0;
         position_tally  = 0;
         pair_results_due.delete();
         fail_count = 0;
      end else begin
         // compare first: a result always belongs to an earlier pair
         if (rsp_valid && rsp_ready) begin
            if (pair_results_due.size() == 0) begin
               $error("unexpected result transaction: distance %0d", rsp_distance);
               fail_count++;
            end else begin
               due = pair_results_due.pop_front();
               if (rsp_distance !== due.distance) begin
                  $error("distance: expected %0d, actual %0d", due.distance, rsp_distance);
                  fail_count++;
               end
               if (rsp_mismatch_count !== due.mismatch_count) begin
                  $error("mismatch_count: expected %0d, actual %0d",
                         due.mismatch_count, rsp_mismatch_count);
                  fail_count++;
               end
               if (rsp_usable_count !== due.usable_count) begin
                  $error("usable_count: expected %0d, actual %0d",
                         due.usable_count, rsp_usable_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            a = fold_case(req_base_a);
            b = fold_case(req_base_b);
            if (bases_clash(a, b))
               mismatch_tally = bump(mismatch_tally);
            if (a == CH_GAP || b == CH_GAP || a == CH_PLUS || b == CH_PLUS
                || a == CH_N || b == CH_N)
               ambiguous_tally = bump(ambiguous_tally);
            position_tally = bump(position_tally);
            if (req_last) begin
               pair_results_due.push_back(p_distance_q16(mismatch_tally, ambiguous_tally,
                                                         position_tally));
               mismatch_tally  = 0;
               ambiguous_tally = 0;
               position_tally  = 0;
            end
         end
      end
      pending = pair_results_due.size();
   end

endmodule

// ----- bench/tb.sv -----
// Stimulus and verdict for the DNA pair p-distance block.
`timescale 1ns / 1ps
module tb;
   import dpd_pkg::*;

   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  PHASE_ITEMS = 120;
   localparam string ALPHABET  = "ACGTMRWSYKVHDBN-+";
   localparam string SINGLES   = "ACGT";

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_base_a = 8'd0;
   logic [7:0]        req_base_b = 8'd0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DIST_W-1:0] rsp_distance;
   logic [CNT_W-1:0]  rsp_mismatch_count;
   logic [CNT_W-1:0]  rsp_usable_count;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   dna_pair_p_distance #(.MAX_LEN(65536)) uut (.*);

   dpd_result_check #(.MAX_LEN(65536)) result_check (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   task automatic send_item(input logic [7:0] a, input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_base_a <= a;
      req_base_b <= b;
      req_last   <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   function automatic logic [7:0] random_base();
      logic [7:0] c;
      int pick;
      pick = $urandom_range(99);
      if (pick < 15)
         c = 8'($urandom_range(255));
      else if (pick < 35)
         c = SINGLES[$urandom_range(3)];
      else
         c = ALPHABET[$urandom_range(ALPHABET.len() - 1)];
      if (c >= "A" && c <= "Z" && $urandom_range(1) == 1)
         c = c + 8'd32;
      return c;
   endfunction

   initial begin
      logic [7:0] a;
      int sent;
      int len;
      int phase;
      int idle_by_phase[4];
      int stall_by_phase[4];

      idle_by_phase  = '{0, 70, 0, 18};
      stall_by_phase = '{0, 0, 70, 18};

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // single-position pairs: match, mismatch, gap against plus, all N; then a three-position pair
      send_item("A", "A", 1'b1);
      send_item("a", "c", 1'b1);
      send_item("-", "+", 1'b1);
      send_item("N", "n", 1'b1);
      send_item("+", "-", 1'b0);
      send_item("g", "G", 1'b0);
      send_item("t", "A", 1'b1);
      // ambiguity codes, unknown bytes and ambiguous positions in one pair
      send_item("M", "K", 1'b0);
      send_item("R", "y", 1'b0);
      send_item("w", "S", 1'b0);
      send_item("V", "T", 1'b0);
      send_item("B", "A", 1'b0);
      send_item("X", "A", 1'b0);
      send_item("x", "m", 1'b0);
      send_item(8'hFF, 8'h00, 1'b0);
      send_item(8'h80, "g", 1'b0);
      send_item("H", "D", 1'b0);
      send_item("-", "-", 1'b0);
      send_item("+", "c", 1'b0);
      send_item("N", "A", 1'b1);
      // truncated fraction
      send_item("A", "C", 1'b0);
      send_item("A", "A", 1'b0);
      send_item("A", "A", 1'b1);

      for (phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_by_phase[phase];
         stall_pct = stall_by_phase[phase];
         if (phase == 0) begin
            // gap/plus mismatches over one usable position: distance saturates
            for (int i = 0; i < 300; i++) begin
               if ($urandom_range(1) == 1)
                  send_item("-", "+", 1'b0);
               else
                  send_item("+", "-", 1'b0);
            end
            a = SINGLES[$urandom_range(3)];
            send_item(a, a, 1'b1);
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 24);
            for (int i = 0; i < len; i++)
               send_item(random_base(), random_base(), i == len - 1);
            sent += len;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
